### hdl/fcct_pkg.sv
// ----------------------------------------------------------------------------
// FAT12 cluster chain table package
// Request codes, table constants and the sequencer's control store.
// ----------------------------------------------------------------------------
package fcct_pkg;

    localparam int ENTRY_W = 12;
    localparam int SCAN_W  = ENTRY_W + 1;

    localparam logic [1:0] FUNC_READ  = 2'd0;
    localparam logic [1:0] FUNC_WRITE = 2'd1;
    localparam logic [1:0] FUNC_ALLOC = 2'd2;
    localparam logic [1:0] FUNC_NOP   = 2'd3;

    localparam logic [ENTRY_W-1:0] EOC_MIN        = 12'hFF8;
    localparam logic [ENTRY_W-1:0] EOC_MARK       = 12'hFF8;
    localparam logic [ENTRY_W-1:0] HIGHEST_RESET  = 12'd4087;
    localparam logic [SCAN_W-1:0]  SCAN_FIRST     = 13'd2;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_DISPATCH,
        S_CHECK_NOP,
        S_EVAL,
        S_SCAN_INIT,
        S_SCAN,
        S_SCAN_EXIT,
        S_LINK,
        S_MARK,
        S_WRITE,
        S_FULL,
        S_RESULT
    } step_t;

    typedef enum logic [3:0] {
        C_NEVER,
        C_ALWAYS,
        C_ACCEPT,
        C_FUNC_WRITE,
        C_FUNC_NOP,
        C_SUCC_OR_READ,
        C_SCAN_STOP,
        C_NOT_FOUND,
        C_OUT_FREE,
        C_CLEAR_DONE
    } cond_t;

    typedef enum logic [2:0] {
        R_NONE,
        R_RD_CLUSTER,
        R_RD_SCAN,
        R_WR_CLEAR,
        R_WR_CLUSTER_VAL,
        R_WR_CLUSTER_RES,
        R_WR_RES_MARK
    } ramop_t;

    typedef enum logic [2:0] {
        A_NONE,
        A_LATCH_IN,
        A_EVAL_SUCC,
        A_SCAN_INIT,
        A_SCAN_STEP,
        A_SET_FULL,
        A_PUSH_OUT,
        A_CLEAR_STEP
    } act_t;

    typedef struct packed {
        logic   in_ready;
        cond_t  cond;
        logic   hold;
        step_t  target;
        ramop_t ram_op;
        act_t   act;
    } ctrl_word_t;

    // Control store. When the condition holds the sequencer jumps to the
    // target, otherwise it stays (hold) or steps to the next word.
    function automatic ctrl_word_t fcct_ucode(input step_t step);
        ctrl_word_t cw;
        cw = '{1'b0, C_NEVER, 1'b0, S_IDLE, R_NONE, A_NONE};
        case (step)
            S_CLEAR:     cw = '{1'b0, C_CLEAR_DONE,   1'b1, S_IDLE,      R_WR_CLEAR,
                                A_CLEAR_STEP};
            S_IDLE:      cw = '{1'b1, C_ACCEPT,       1'b1, S_DISPATCH,  R_NONE,
                                A_LATCH_IN};
            S_DISPATCH:  cw = '{1'b0, C_FUNC_WRITE,   1'b0, S_WRITE,     R_RD_CLUSTER,
                                A_NONE};
            S_CHECK_NOP: cw = '{1'b0, C_FUNC_NOP,     1'b0, S_RESULT,    R_NONE, A_NONE};
            S_EVAL:      cw = '{1'b0, C_SUCC_OR_READ, 1'b0, S_RESULT,    R_NONE,
                                A_EVAL_SUCC};
            S_SCAN_INIT: cw = '{1'b0, C_NEVER,        1'b0, S_IDLE,      R_NONE,
                                A_SCAN_INIT};
            S_SCAN:      cw = '{1'b0, C_SCAN_STOP,    1'b1, S_SCAN_EXIT, R_RD_SCAN,
                                A_SCAN_STEP};
            S_SCAN_EXIT: cw = '{1'b0, C_NOT_FOUND,    1'b0, S_FULL,      R_NONE, A_NONE};
            S_LINK:      cw = '{1'b0, C_NEVER,        1'b0, S_IDLE,      R_WR_CLUSTER_RES,
                                A_NONE};
            S_MARK:      cw = '{1'b0, C_ALWAYS,       1'b0, S_RESULT,    R_WR_RES_MARK,
                                A_NONE};
            S_WRITE:     cw = '{1'b0, C_ALWAYS,       1'b0, S_RESULT,    R_WR_CLUSTER_VAL,
                                A_NONE};
            S_FULL:      cw = '{1'b0, C_NEVER,        1'b0, S_IDLE,      R_NONE, A_SET_FULL};
            S_RESULT:    cw = '{1'b0, C_OUT_FREE,     1'b1, S_IDLE,      R_NONE, A_PUSH_OUT};
            default:     cw = '{1'b0, C_ALWAYS,       1'b0, S_IDLE,      R_NONE, A_NONE};
        endcase
        return cw;
    endfunction

endpackage

### hdl/fcct_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module fcct_ram #(
    parameter int WIDTH = 12,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### hdl/fat12_cluster_chain_table_top.sv
// ----------------------------------------------------------------------------
// FAT12 cluster chain table
// Allocation table of 12-bit entries with read, write and allocate requests.
// ----------------------------------------------------------------------------
// After reset the block clears its table, one entry a cycle; requests are
// held off until then, while configuration writes are taken at any time. A
// small control program steps through each request over the one table RAM.
// A read passes through dispatch, check, evaluate and result steps; a write
// goes from dispatch to write to result, an unused request code from dispatch
// to check to result. An allocate that finds a successor ends like a read;
// one that scans reads one entry per cycle from cluster 2 upward, then links,
// marks and reports the new cluster, or reports a full table. A new request
// is accepted while the previous result still waits in the output register.
module fat12_cluster_chain_table_top
    import fcct_pkg::*;
#(
    parameter int TABLE_ENTRIES = 4096
) (
    input  logic        clk,
    input  logic        rst_n,
    // Configuration: highest_cluster.
    input  logic        cfg_wr_en,
    input  logic [11:0] cfg_wr_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [11:0] cluster, [23:12] entry_value.
    input  logic [23:0] s_tdata,
    // [1:0] func.
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [11:0] result_cluster, [15:12] zero.
    output logic [15:0] m_tdata,
    // [0] end_of_chain, [1] table_full.
    output logic [1:0]  m_tuser
);

    localparam int ADDR_W = $clog2(TABLE_ENTRIES);
    localparam logic [SCAN_W-1:0] LAST_MAX   = SCAN_W'(TABLE_ENTRIES - 1);
    localparam logic [SCAN_W-1:0] ENTRIES_SZ = SCAN_W'(TABLE_ENTRIES);
    localparam logic [ADDR_W-1:0] CLEAR_LAST = ADDR_W'(TABLE_ENTRIES - 1);

    step_t               step_reg, step_next;
    logic [1:0]          func_reg, func_next;
    logic [ENTRY_W-1:0]  cluster_reg, cluster_next;
    logic [ENTRY_W-1:0]  value_reg, value_next;
    logic [ENTRY_W-1:0]  res_reg, res_next;
    logic                eoc_reg, eoc_next;
    logic                full_reg, full_next;
    logic                found_reg, found_next;
    logic                pend_reg, pend_next;
    logic [SCAN_W-1:0]   scan_reg, scan_next;
    logic [ADDR_W-1:0]   clr_reg, clr_next;
    logic [ENTRY_W-1:0]  highest_reg, highest_next;
    logic                out_valid_reg, out_valid_next;
    logic [ENTRY_W-1:0]  out_cluster_reg, out_cluster_next;
    logic                out_eoc_reg, out_eoc_next;
    logic                out_full_reg, out_full_next;

    ctrl_word_t          cw;
    logic                accept;
    logic                in_range;
    logic [ENTRY_W-1:0]  rd_val;
    logic                succ_ok;
    logic [SCAN_W-1:0]   last;
    logic [SCAN_W-1:0]   scan_prev;
    logic                hit;
    logic                issue;
    logic                out_free;
    logic                jump;

    logic                ram_wr_en;
    logic [ADDR_W-1:0]   ram_wr_addr;
    logic [ENTRY_W-1:0]  ram_wr_data;
    logic                ram_rd_en;
    logic [ADDR_W-1:0]   ram_rd_addr;
    logic [ENTRY_W-1:0]  ram_rd_data;

    fcct_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_table (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    assign cw       = fcct_ucode(step_reg);
    assign s_tready = cw.in_ready;
    assign accept   = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;

    // Clusters past the end of the table read as free entries.
    assign in_range = {1'b0, cluster_reg} < ENTRIES_SZ;
    assign rd_val   = in_range ? ram_rd_data : '0;
    assign succ_ok  = (cluster_reg != '0) && (rd_val < EOC_MIN);

    assign last      = ({1'b0, highest_reg} > LAST_MAX) ? LAST_MAX : {1'b0, highest_reg};
    assign scan_prev = scan_reg - SCAN_W'(1);
    // The entry read in the previous scan cycle is checked while the next is read.
    assign hit       = pend_reg && (ram_rd_data == '0);
    assign issue     = (scan_reg <= last) && !hit;

    always_comb
    begin
        case (cw.cond)
            C_NEVER:        jump = 1'b0;
            C_ALWAYS:       jump = 1'b1;
            C_ACCEPT:       jump = accept;
            C_FUNC_WRITE:   jump = func_reg == FUNC_WRITE;
            C_FUNC_NOP:     jump = func_reg == FUNC_NOP;
            C_SUCC_OR_READ: jump = succ_ok || (func_reg == FUNC_READ);
            C_SCAN_STOP:    jump = hit || (!pend_reg && (scan_reg > last));
            C_NOT_FOUND:    jump = !found_reg;
            C_OUT_FREE:     jump = out_free;
            C_CLEAR_DONE:   jump = clr_reg == CLEAR_LAST;
            default:        jump = 1'b0;
        endcase

        if (jump)
        begin
            step_next = cw.target;
        end
        else if (cw.hold)
        begin
            step_next = step_reg;
        end
        else
        begin
            step_next = step_t'(4'(step_reg + 4'd1));
        end
    end

    always_comb
    begin
        ram_wr_en   = 1'b0;
        ram_wr_addr = cluster_reg[ADDR_W-1:0];
        ram_wr_data = value_reg;
        ram_rd_en   = 1'b0;
        ram_rd_addr = cluster_reg[ADDR_W-1:0];
        case (cw.ram_op)
            R_NONE:
            begin
                ram_wr_en = 1'b0;
            end
            R_RD_CLUSTER:
            begin
                ram_rd_en = 1'b1;
            end
            R_RD_SCAN:
            begin
                ram_rd_en   = issue;
                ram_rd_addr = scan_reg[ADDR_W-1:0];
            end
            R_WR_CLEAR:
            begin
                ram_wr_en   = 1'b1;
                ram_wr_addr = clr_reg;
                ram_wr_data = '0;
            end
            R_WR_CLUSTER_VAL:
            begin
                ram_wr_en = in_range;
            end
            R_WR_CLUSTER_RES:
            begin
                // A new chain from cluster zero links nothing.
                ram_wr_en   = in_range && (cluster_reg != '0);
                ram_wr_data = res_reg;
            end
            R_WR_RES_MARK:
            begin
                ram_wr_en   = 1'b1;
                ram_wr_addr = res_reg[ADDR_W-1:0];
                ram_wr_data = EOC_MARK;
            end
            default:
            begin
                ram_wr_en = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        func_next        = func_reg;
        cluster_next     = cluster_reg;
        value_next       = value_reg;
        res_next         = res_reg;
        eoc_next         = eoc_reg;
        full_next        = full_reg;
        found_next       = found_reg;
        pend_next        = pend_reg;
        scan_next        = scan_reg;
        clr_next         = clr_reg;
        highest_next     = cfg_wr_en ? cfg_wr_data : highest_reg;
        out_valid_next   = out_valid_reg && !m_tready;
        out_cluster_next = out_cluster_reg;
        out_eoc_next     = out_eoc_reg;
        out_full_next    = out_full_reg;

        case (cw.act)
            A_NONE:
            begin
                pend_next = pend_reg;
            end
            A_LATCH_IN:
            begin
                if (accept)
                begin
                    func_next    = s_tuser;
                    cluster_next = s_tdata[11:0];
                    value_next   = s_tdata[23:12];
                    res_next     = '0;
                    eoc_next     = 1'b0;
                    full_next    = 1'b0;
                    found_next   = 1'b0;
                end
            end
            A_EVAL_SUCC:
            begin
                res_next = succ_ok ? rd_val : '0;
                eoc_next = (func_reg == FUNC_READ) && !succ_ok;
            end
            A_SCAN_INIT:
            begin
                scan_next = SCAN_FIRST;
                pend_next = 1'b0;
            end
            A_SCAN_STEP:
            begin
                if (hit)
                begin
                    res_next   = scan_prev[ENTRY_W-1:0];
                    found_next = 1'b1;
                end
                pend_next = issue;
                if (issue)
                begin
                    scan_next = scan_reg + SCAN_W'(1);
                end
            end
            A_SET_FULL:
            begin
                full_next = 1'b1;
            end
            A_PUSH_OUT:
            begin
                if (out_free)
                begin
                    out_valid_next   = 1'b1;
                    out_cluster_next = res_reg;
                    out_eoc_next     = eoc_reg;
                    out_full_next    = full_reg;
                end
            end
            A_CLEAR_STEP:
            begin
                clr_next = clr_reg + ADDR_W'(1);
            end
            default:
            begin
                pend_next = pend_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= S_CLEAR;
            clr_reg       <= '0;
            highest_reg   <= HIGHEST_RESET;
            out_valid_reg <= 1'b0;
            pend_reg      <= 1'b0;
            found_reg     <= 1'b0;
        end
        else
        begin
            step_reg      <= step_next;
            clr_reg       <= clr_next;
            highest_reg   <= highest_next;
            out_valid_reg <= out_valid_next;
            pend_reg      <= pend_next;
            found_reg     <= found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg        <= func_next;
        cluster_reg     <= cluster_next;
        value_reg       <= value_next;
        res_reg         <= res_next;
        eoc_reg         <= eoc_next;
        full_reg        <= full_next;
        scan_reg        <= scan_next;
        out_cluster_reg <= out_cluster_next;
        out_eoc_reg     <= out_eoc_next;
        out_full_reg    <= out_full_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0000, out_cluster_reg};
    assign m_tuser  = {out_full_reg, out_eoc_reg};

    // A full table and an end of chain never come together.
    a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
        else $error("end_of_chain and table_full both set");

    // A full table reports no cluster.
    a_full_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser[1]) |-> (m_tdata[11:0] == 12'd0))
        else $error("table_full with nonzero result_cluster");

    // The scan pointer never runs past one beyond the scan limit.
    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (step_reg == S_SCAN) |-> (scan_reg <= last + SCAN_W'(1)))
        else $error("scan pointer out of bounds");

    // The table is never asked to read and write in the same cycle.
    a_one_port_op: assert property (@(posedge clk) disable iff (!rst_n)
        !(ram_wr_en && ram_rd_en))
        else $error("table read and write in the same cycle");

endmodule

### bench/tb_top.sv
// ----------------------------------------------------------------------------
// FAT12 cluster chain table testbench
// Sends read, write, allocate and unused requests over the stream input and
// checks each result, field by field, against a table model kept in the bench
// or a result given by a directed row. A short directed list covers the corner
// cases, then random chain-building traffic runs under several scan limits.
// ----------------------------------------------------------------------------
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    import fcct_pkg::*;

    localparam int TABLE_DEPTH  = 4096;
    localparam int STALL_LIMIT  = 40000;
    localparam int HOLD_CYCLES  = 250;
    localparam int PHASE_ITEMS  = 19;

    typedef struct packed {
        logic [11:0] next_cluster;
        logic        end_of_chain;
        logic        table_full;
    } fat_result_t;

    typedef enum logic {ROW_REQ, ROW_CFG} row_kind_t;

    typedef struct packed {
        row_kind_t   kind;
        logic [1:0]  func;
        logic [11:0] cluster;
        logic [11:0] value;
        logic        typed;
        fat_result_t result;
    } dir_row_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_wr_en;
    logic [11:0] cfg_wr_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;
    logic [1:0]  m_tuser;

    logic [11:0] fat_table [TABLE_DEPTH];
    logic [11:0] scan_limit;
    fat_result_t awaited_results [$];
    dir_row_t    dir_rows [$];
    int          mismatches;
    bit          steady;
    bit          hold_req;

    fat12_cluster_chain_table_top u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #6 clk = ~clk;
        end
    end

    // Works out the result of one request and updates the table copy.
    function automatic fat_result_t chain_predict(input logic [1:0] func,
                                                  input logic [11:0] clu,
                                                  input logic [11:0] val);
        fat_result_t r;
        logic [11:0] cur;
        int          last;
        int          idx;
        r = '0;
        cur = fat_table[clu];
        case (func)
            FUNC_READ:
            begin
                if (clu != 12'd0 && cur < EOC_MIN)
                    r.next_cluster = cur;
                else
                    r.end_of_chain = 1'b1;
            end
            FUNC_WRITE:
            begin
                fat_table[clu] = val;
            end
            FUNC_ALLOC:
            begin
                if (clu != 12'd0 && cur < EOC_MIN)
                begin
                    r.next_cluster = cur;
                end
                else
                begin
                    last = (int'(scan_limit) > TABLE_DEPTH - 1) ? TABLE_DEPTH - 1
                                                                 : int'(scan_limit);
                    idx = 2;
                    while (idx <= last && fat_table[idx] != 12'd0)
                        idx++;
                    if (idx <= last)
                    begin
                        if (clu != 12'd0)
                            fat_table[clu] = idx[11:0];
                        fat_table[idx] = EOC_MARK;
                        r.next_cluster = idx[11:0];
                    end
                    else
                    begin
                        r.table_full = 1'b1;
                    end
                end
            end
            default:
            begin
            end
        endcase
        return r;
    endfunction

    task automatic add_row(input row_kind_t kind, input logic [1:0] func,
                           input logic [11:0] clu, input logic [11:0] val,
                           input logic typed, input logic [11:0] res,
                           input logic eoc, input logic full);
        dir_row_t row;
        row.kind = kind;
        row.func = func;
        row.cluster = clu;
        row.value = val;
        row.typed = typed;
        row.result.next_cluster = res;
        row.result.end_of_chain = eoc;
        row.result.table_full = full;
        dir_rows.push_back(row);
    endtask

    // Offers one request and records its expected result on acceptance.
    task automatic send_request(input logic [1:0] func, input logic [11:0] clu,
                                input logic [11:0] val, input logic typed,
                                input fat_result_t typed_result,
                                output fat_result_t predicted);
        @(negedge clk);
        while (!steady && $urandom_range(0, 99) < 20)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {val, clu};
        s_tuser  <= func;
        do
            @(posedge clk);
        while (!s_tready);
        predicted = chain_predict(func, clu, val);
        awaited_results.push_back(typed ? typed_result : predicted);
    endtask

    // The register is only written once every result has come back.
    task automatic write_scan_limit(input logic [11:0] v);
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (awaited_results.size() != 0)
            @(posedge clk);
        @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
        scan_limit = v;
    endtask

    // Result checker.
    always @(posedge clk)
    begin
        fat_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (awaited_results.size() == 0)
            begin
                $error("result with nothing awaited: cluster %0d", m_tdata[11:0]);
                mismatches++;
            end
            else
            begin
                want = awaited_results.pop_front();
                if (m_tdata[11:0] !== want.next_cluster)
                begin
                    $error("result_cluster: expected %0d, got %0d",
                           want.next_cluster, m_tdata[11:0]);
                    mismatches++;
                end
                if (m_tuser[0] !== want.end_of_chain)
                begin
                    $error("end_of_chain: expected %0b, got %0b",
                           want.end_of_chain, m_tuser[0]);
                    mismatches++;
                end
                if (m_tuser[1] !== want.table_full)
                begin
                    $error("table_full: expected %0b, got %0b",
                           want.table_full, m_tuser[1]);
                    mismatches++;
                end
            end
        end
    end

    // Receiver: random back-pressure, a long hold-off on request, and none
    // at all while the steady flag is set.
    initial
    begin
        int hold_left;
        hold_left = 0;
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req && hold_left == 0)
            begin
                hold_left = HOLD_CYCLES;
                hold_req = 1'b0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else if (steady)
                m_tready <= 1'b1;
            else
                m_tready <= ($urandom_range(0, 99) >= 20);
        end
    end

    // Watchdog on cycles without any handshake; the post-reset clear and a
    // full-table scan both fit well inside the limit.
    initial
    begin
        int quiet_cycles;
        quiet_cycles = 0;
        forever
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wr_en)
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    initial
    begin
        int          phase_limits [6];
        int          lim;
        int          pick;
        logic [1:0]  func;
        logic [11:0] clu;
        logic [11:0] val;
        logic [11:0] walk;
        fat_result_t pred;

        phase_limits = '{40, 16, 4087, 2, 300, 4087};
        mismatches  = 0;
        steady      = 1'b0;
        hold_req    = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = '0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = FUNC_READ;
        rst_n       = 1'b0;
        walk        = '0;
        for (int i = 0; i < TABLE_DEPTH; i++)
            fat_table[i] = '0;
        scan_limit = HIGHEST_RESET;

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed part, starting on the reset value of the scan limit.
        add_row(ROW_REQ, FUNC_READ,  12'd0,    12'd0,   1'b1, 12'd0, 1'b1, 1'b0);
        add_row(ROW_REQ, FUNC_READ,  12'd4095, 12'd0,   1'b1, 12'd0, 1'b0, 1'b0);
        add_row(ROW_REQ, FUNC_ALLOC, 12'd0,    12'd0,   1'b1, 12'd2, 1'b0, 1'b0);
        add_row(ROW_REQ, FUNC_ALLOC, 12'd2,    12'd0,   1'b0, 12'd0, 1'b0, 1'b0);
        add_row(ROW_REQ, FUNC_READ,  12'd2,    12'd0,   1'b0, 12'd0, 1'b0, 1'b0);
        add_row(ROW_REQ, FUNC_READ,  12'd3,    12'd0,   1'b0, 12'd0, 1'b0, 1'b0);
        add_row(ROW_REQ, FUNC_ALLOC, 12'd2,    12'd0,   1'b0, 12'd0, 1'b0, 1'b0);
        // A free entry counts as a successor of zero, so no scan runs.
        add_row(ROW_REQ, FUNC_ALLOC, 12'd4095, 12'd0,   1'b1, 12'd0, 1'b0, 1'b0);
        add_row(ROW_REQ, FUNC_WRITE, 12'd4095, 12'hFFF, 1'b1, 12'd0, 1'b0, 1'b0);
        add_row(ROW_REQ, FUNC_READ,  12'd4095, 12'd0,   1'b1, 12'd0, 1'b1, 1'b0);
        // Reserved and bad markers read as ordinary successors.
        add_row(ROW_REQ, FUNC_WRITE, 12'd10,   12'hFF0, 1'b1, 12'd0, 1'b0, 1'b0);
        add_row(ROW_REQ, FUNC_READ,  12'd10,   12'd0,   1'b0, 12'd0, 1'b0, 1'b0);
        add_row(ROW_REQ, FUNC_ALLOC, 12'd10,   12'd0,   1'b0, 12'd0, 1'b0, 1'b0);
        add_row(ROW_REQ, FUNC_WRITE, 12'd11,   12'hFF7, 1'b1, 12'd0, 1'b0, 1'b0);
        add_row(ROW_REQ, FUNC_READ,  12'd11,   12'd0,   1'b0, 12'd0, 1'b0, 1'b0);
        add_row(ROW_REQ, FUNC_WRITE, 12'd12,   12'hFF8, 1'b1, 12'd0, 1'b0, 1'b0);
        add_row(ROW_REQ, FUNC_ALLOC, 12'd12,   12'd0,   1'b0, 12'd0, 1'b0, 1'b0);
        add_row(ROW_REQ, FUNC_NOP,   12'd5,    12'hABC, 1'b1, 12'd0, 1'b0, 1'b0);
        // Cluster zero ends a chain whatever its entry holds.
        add_row(ROW_REQ, FUNC_WRITE, 12'd0,    12'h555, 1'b1, 12'd0, 1'b0, 1'b0);
        add_row(ROW_REQ, FUNC_READ,  12'd0,    12'd0,   1'b1, 12'd0, 1'b1, 1'b0);
        add_row(ROW_REQ, FUNC_ALLOC, 12'd0,    12'd0,   1'b0, 12'd0, 1'b0, 1'b0);
        add_row(ROW_REQ, FUNC_WRITE, 12'd4095, 12'd0,   1'b1, 12'd0, 1'b0, 1'b0);
        add_row(ROW_CFG, FUNC_NOP,   12'd0,    12'd2,   1'b0, 12'd0, 1'b0, 1'b0);
        add_row(ROW_REQ, FUNC_ALLOC, 12'd0,    12'd0,   1'b0, 12'd0, 1'b0, 1'b0);
        // A limit below the first data cluster leaves nothing to scan.
        add_row(ROW_CFG, FUNC_NOP,   12'd0,    12'd1,   1'b0, 12'd0, 1'b0, 1'b0);
        add_row(ROW_REQ, FUNC_ALLOC, 12'd0,    12'd0,   1'b1, 12'd0, 1'b0, 1'b1);
        add_row(ROW_REQ, FUNC_ALLOC, 12'd3,    12'd0,   1'b0, 12'd0, 1'b0, 1'b0);

        foreach (dir_rows[i])
        begin
            if (dir_rows[i].kind == ROW_CFG)
                write_scan_limit(dir_rows[i].value);
            else
                send_request(dir_rows[i].func, dir_rows[i].cluster, dir_rows[i].value,
                             dir_rows[i].typed, dir_rows[i].result, pred);
        end

        // Random part: chains are extended and walked most of the time,
        // with stray writes, free-ups and unused codes mixed in.
        for (int ph = 0; ph < 6; ph++)
        begin
            write_scan_limit(phase_limits[ph][11:0]);
            steady   = (ph == 2);
            hold_req = (ph == 1);
            lim = (phase_limits[ph] < 60) ? phase_limits[ph] : 60;
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 35)
                    func = FUNC_READ;
                else if (pick < 60)
                    func = FUNC_WRITE;
                else if (pick < 95)
                    func = FUNC_ALLOC;
                else
                    func = FUNC_NOP;

                pick = $urandom_range(0, 99);
                if (pick < 40)
                    clu = walk;
                else if (pick < 75)
                    clu = 12'($urandom_range(0, lim + 4));
                else if (pick < 85)
                    clu = 12'd0;
                else
                    clu = 12'($urandom_range(0, 4095));

                pick = $urandom_range(0, 99);
                if (pick < 40)
                    val = 12'd0;
                else if (pick < 60)
                    val = 12'($urandom_range(2, lim + 2));
                else if (pick < 75)
                    val = 12'($urandom_range(12'hFF0, 12'hFFF));
                else
                    val = 12'($urandom_range(0, 4095));

                send_request(func, clu, val, 1'b0, '0, pred);
                if (pred.next_cluster != 12'd0)
                    walk = pred.next_cluster;
                else if (pred.end_of_chain || pred.table_full)
                    walk = 12'($urandom_range(0, lim + 2));
            end
        end
        steady = 1'b0;

        @(negedge clk);
        s_tvalid <= 1'b0;
        while (awaited_results.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
